// File: hdl/touch_keypad_pin_lock_defines.svh
// Assertion macros used by the port checker of the PIN lock.
`ifndef TOUCH_KEYPAD_PIN_LOCK_DEFINES_SVH
`define TOUCH_KEYPAD_PIN_LOCK_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define TKPL_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tkpl check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define TKPL_ASSERT_NXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tkpl check failed");

`endif

// File: hdl/tkpl_pkg.sv
// ----------------------------------------------------------------------------
// tkpl_pkg
// Shared types, register indexes, reset values and the key rectangle table
// of the touch keypad PIN lock.
// ----------------------------------------------------------------------------
`default_nettype none

package tkpl_pkg;

  localparam int unsigned SampleW = 12;
  localparam int unsigned GainW   = 16;
  localparam int unsigned CoordW  = 8;
  localparam int unsigned KeyW    = 4;
  localparam int unsigned CountW  = 3;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 16;
  localparam int unsigned KeyCount = 10;

  localparam logic [KeyW-1:0] NoKey = 4'd10;

  // Register indexes of the configuration port.
  typedef enum logic [CfgIdxW-1:0] {
    REG_PIN_FIRST  = 3'd0,
    REG_PIN_SECOND = 3'd1,
    REG_PIN_THIRD  = 3'd2,
    REG_PIN_FOURTH = 3'd3,
    REG_X_OFFSET   = 3'd4,
    REG_Y_OFFSET   = 3'd5,
    REG_X_GAIN     = 3'd6,
    REG_Y_GAIN     = 3'd7
  } cfg_idx_e;

  localparam logic [KeyW-1:0]    PinFirstRst  = 4'd9;
  localparam logic [KeyW-1:0]    PinSecondRst = 4'd6;
  localparam logic [KeyW-1:0]    PinThirdRst  = 4'd3;
  localparam logic [KeyW-1:0]    PinFourthRst = 4'd0;
  localparam logic [SampleW-1:0] XOffsetRst   = 12'd220;
  localparam logic [SampleW-1:0] YOffsetRst   = 12'd520;
  localparam logic [GainW-1:0]   XGainRst     = 16'd2451;
  localparam logic [GainW-1:0]   YGainRst     = 16'd1431;

  typedef struct packed {
    logic [CoordW-1:0] xlo;
    logic [CoordW-1:0] xhi;
    logic [CoordW-1:0] ylo;
    logic [CoordW-1:0] yhi;
    logic [KeyW-1:0]   digit;
  } key_rect_t;

  // Earlier entries take priority where rectangles could overlap.
  localparam key_rect_t KeyTable [KeyCount] = '{
    '{8'd14, 8'd25, 8'd0,  8'd14, 4'd0},
    '{8'd26, 8'd38, 8'd15, 8'd29, 4'd9},
    '{8'd14, 8'd25, 8'd15, 8'd29, 4'd8},
    '{8'd2,  8'd13, 8'd15, 8'd29, 4'd7},
    '{8'd26, 8'd38, 8'd30, 8'd43, 4'd6},
    '{8'd14, 8'd25, 8'd30, 8'd43, 4'd5},
    '{8'd2,  8'd13, 8'd30, 8'd43, 4'd4},
    '{8'd26, 8'd38, 8'd44, 8'd58, 4'd3},
    '{8'd14, 8'd25, 8'd44, 8'd58, 4'd2},
    '{8'd2,  8'd13, 8'd44, 8'd58, 4'd1}
  };

  // All bounds are strict. Scanning from the back lets the first hit win.
  function automatic logic [KeyW-1:0] decode_key(logic [CoordW-1:0] x,
                                                 logic [CoordW-1:0] y);
    logic [KeyW-1:0] key;
    key = NoKey;
    for (int i = KeyCount - 1; i >= 0; i--) begin
      if (x > KeyTable[i].xlo && x < KeyTable[i].xhi &&
          y > KeyTable[i].ylo && y < KeyTable[i].yhi) begin
        key = KeyTable[i].digit;
      end
    end
    return key;
  endfunction

endpackage

`default_nettype wire

// File: hdl/tkpl_axis_scale.sv
// ----------------------------------------------------------------------------
// tkpl_axis_scale
// Offset removal, Q0.16 gain and saturation for one panel axis.
// ----------------------------------------------------------------------------
`default_nettype none

module tkpl_axis_scale
  import tkpl_pkg::*;
(
  input  wire logic [SampleW-1:0] sample_i,
  input  wire logic [SampleW-1:0] offset_i,
  input  wire logic [GainW-1:0]   gain_i,
  output logic      [CoordW-1:0]  coord_o
);

  logic [SampleW-1:0]       diff;
  logic [SampleW+GainW-1:0] prod;
  logic [SampleW-1:0]       scaled;

  // A sample below the panel edge clamps to zero rather than wrapping.
  assign diff   = (sample_i > offset_i) ? (sample_i - offset_i) : '0;
  assign prod   = {{GainW{1'b0}}, diff} * {{SampleW{1'b0}}, gain_i};
  assign scaled = prod[SampleW+GainW-1:GainW];
  assign coord_o = (|scaled[SampleW-1:CoordW]) ? '1 : scaled[CoordW-1:0];

endmodule

`default_nettype wire

// File: hdl/touch_keypad_pin_lock.sv
// ----------------------------------------------------------------------------
// touch_keypad_pin_lock
// Touch panel keypad decoder with a four-digit PIN sequencer.
// ----------------------------------------------------------------------------
// The block takes one pair of raw panel samples per clock while the input is
// not stalled and gives one result per sample: the samples land in an input
// register, and the offset, gain multiply, key lookup and PIN step are done
// as the sample moves on into the result register. A result held by a
// stalled output does not stop the input register from taking one more
// sample; the input stalls only while both registers are full. Configuration
// writes take effect on the next clock edge and are meant to be made while no
// sample is in flight.
`default_nettype none

module touch_keypad_pin_lock
  import tkpl_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [CfgW-1:0]    cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [SampleW-1:0] x_sample_i,
  input  wire logic [SampleW-1:0] y_sample_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic      [CoordW-1:0]  x_coord_o,
  output logic      [CoordW-1:0]  y_coord_o,
  output logic      [KeyW-1:0]    key_code_o,
  output logic      [CountW-1:0]  digits_matched_o,
  output logic                    wrong_digit_o,
  output logic                    pin_accepted_o
);

  typedef enum logic [4:0] {
    ST_WAIT_FIRST  = 5'b00001,
    ST_WAIT_SECOND = 5'b00010,
    ST_WAIT_THIRD  = 5'b00100,
    ST_WAIT_FOURTH = 5'b01000,
    ST_COMPLETE    = 5'b10000
  } seq_state_e;

  // Configuration registers.
  logic [KeyW-1:0]    pin_first_q, pin_second_q, pin_third_q, pin_fourth_q;
  logic [SampleW-1:0] x_offset_q, y_offset_q;
  logic [GainW-1:0]   x_gain_q, y_gain_q;

  // Input register.
  logic               in_full_q;
  logic [SampleW-1:0] x_sample_q, y_sample_q;

  // Result register.
  logic               out_full_q;
  logic [CoordW-1:0]  x_coord_q, y_coord_q;
  logic [KeyW-1:0]    key_q;
  logic [CountW-1:0]  matched_q;
  logic               wrong_q, accepted_q;

  seq_state_e         state_q, state_d;
  logic [CoordW-1:0]  x_coord, y_coord;
  logic [KeyW-1:0]    key;
  logic [KeyW-1:0]    expected;
  logic [CountW-1:0]  matched_d;
  logic               wrong_d, accepted_d;
  logic               out_free, advance, in_take;

  assign out_free   = !out_full_q || !out_stall_i;
  assign advance    = in_full_q && out_free;
  assign in_stall_o = in_full_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pin_first_q  <= PinFirstRst;
      pin_second_q <= PinSecondRst;
      pin_third_q  <= PinThirdRst;
      pin_fourth_q <= PinFourthRst;
      x_offset_q   <= XOffsetRst;
      y_offset_q   <= YOffsetRst;
      x_gain_q     <= XGainRst;
      y_gain_q     <= YGainRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        REG_PIN_FIRST:  pin_first_q  <= cfg_data_i[KeyW-1:0];
        REG_PIN_SECOND: pin_second_q <= cfg_data_i[KeyW-1:0];
        REG_PIN_THIRD:  pin_third_q  <= cfg_data_i[KeyW-1:0];
        REG_PIN_FOURTH: pin_fourth_q <= cfg_data_i[KeyW-1:0];
        REG_X_OFFSET:   x_offset_q   <= cfg_data_i[SampleW-1:0];
        REG_Y_OFFSET:   y_offset_q   <= cfg_data_i[SampleW-1:0];
        REG_X_GAIN:     x_gain_q     <= cfg_data_i[GainW-1:0];
        REG_Y_GAIN:     y_gain_q     <= cfg_data_i[GainW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_full_q <= 1'b0;
    end else if (in_take) begin
      in_full_q <= 1'b1;
    end else if (advance) begin
      in_full_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      x_sample_q <= x_sample_i;
      y_sample_q <= y_sample_i;
    end
  end

  tkpl_axis_scale u_x_scale (
    .sample_i (x_sample_q),
    .offset_i (x_offset_q),
    .gain_i   (x_gain_q),
    .coord_o  (x_coord)
  );

  tkpl_axis_scale u_y_scale (
    .sample_i (y_sample_q),
    .offset_i (y_offset_q),
    .gain_i   (y_gain_q),
    .coord_o  (y_coord)
  );

  assign key = decode_key(x_coord, y_coord);

  always_comb begin
    case (state_q)
      ST_WAIT_FIRST:  expected = pin_first_q;
      ST_WAIT_SECOND: expected = pin_second_q;
      ST_WAIT_THIRD:  expected = pin_third_q;
      ST_WAIT_FOURTH: expected = pin_fourth_q;
      default:        expected = NoKey;
    endcase
  end

  // In the complete state the key is ignored and the lock reports acceptance.
  // A blank sample never counts as a wrong digit.
  always_comb begin
    state_d    = state_q;
    wrong_d    = 1'b0;
    accepted_d = 1'b0;
    if (state_q == ST_COMPLETE) begin
      accepted_d = 1'b1;
      state_d    = ST_WAIT_FIRST;
    end else if (key != NoKey) begin
      if (key == expected) begin
        case (state_q)
          ST_WAIT_FIRST:  state_d = ST_WAIT_SECOND;
          ST_WAIT_SECOND: state_d = ST_WAIT_THIRD;
          ST_WAIT_THIRD:  state_d = ST_WAIT_FOURTH;
          ST_WAIT_FOURTH: state_d = ST_COMPLETE;
          default:        state_d = ST_WAIT_FIRST;
        endcase
      end else begin
        state_d = ST_WAIT_FIRST;
        wrong_d = 1'b1;
      end
    end
  end

  always_comb begin
    case (state_d)
      ST_WAIT_FIRST:  matched_d = 3'd0;
      ST_WAIT_SECOND: matched_d = 3'd1;
      ST_WAIT_THIRD:  matched_d = 3'd2;
      ST_WAIT_FOURTH: matched_d = 3'd3;
      ST_COMPLETE:    matched_d = 3'd4;
      default:        matched_d = 3'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_WAIT_FIRST;
      out_full_q <= 1'b0;
    end else begin
      if (advance) begin
        state_q <= state_d;
      end
      if (advance) begin
        out_full_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_full_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      x_coord_q  <= x_coord;
      y_coord_q  <= y_coord;
      key_q      <= key;
      matched_q  <= matched_d;
      wrong_q    <= wrong_d;
      accepted_q <= accepted_d;
    end
  end

  assign out_valid_o      = out_full_q;
  assign x_coord_o        = x_coord_q;
  assign y_coord_o        = y_coord_q;
  assign key_code_o       = key_q;
  assign digits_matched_o = matched_q;
  assign wrong_digit_o    = wrong_q;
  assign pin_accepted_o   = accepted_q;

endmodule

`default_nettype wire

// File: hdl/tkpl_port_check.sv
// ----------------------------------------------------------------------------
// tkpl_port_check
// Port-level checks of the PIN lock, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "touch_keypad_pin_lock_defines.svh"

module tkpl_port_check
  import tkpl_pkg::*;
(
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               out_valid_o,
  input wire logic               out_stall_i,
  input wire logic [KeyW-1:0]    key_code_o,
  input wire logic [CountW-1:0]  digits_matched_o,
  input wire logic               wrong_digit_o,
  input wire logic               pin_accepted_o
);

  // Acceptance always returns the sequencer to its start, with no error.
  `TKPL_ASSERT_IMP(a_accept_resets, clk_i, rst_ni, out_valid_o && pin_accepted_o,
                   !wrong_digit_o && digits_matched_o == 3'd0)

  // A wrong digit clears progress and needs a real key.
  `TKPL_ASSERT_IMP(a_wrong_needs_key, clk_i, rst_ni, out_valid_o && wrong_digit_o,
                   digits_matched_o == 3'd0 && key_code_o != NoKey)

  // Completion is reported only after a key has been pressed.
  `TKPL_ASSERT_IMP(a_complete_on_key, clk_i, rst_ni,
                   out_valid_o && digits_matched_o == 3'd4,
                   key_code_o != NoKey && !pin_accepted_o)

  // A stalled result stays offered and unchanged.
  `TKPL_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
                   out_valid_o && $stable(key_code_o) && $stable(digits_matched_o))

endmodule

bind touch_keypad_pin_lock tkpl_port_check u_port_check (.*);

`default_nettype wire
